### design/slxfr_pkg.sv
`timescale 1ns / 1ps

package slxfr_pkg;

	// Assembly buffer depth; the frame store holds two banks of this size.
	localparam int BUF_DEPTH = 128;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int BYTE_W    = 8;
	localparam int NEED_W    = BYTE_W + 1;
	localparam int CTR_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;

	// Register reset values.
	localparam logic [BYTE_W-1:0] SYNC_RST = 8'hC6;
	localparam logic [BYTE_W-1:0] MIN_RST  = 8'd6;
	localparam logic [BYTE_W-1:0] MAX_RST  = 8'd128;

	// Frame length is the length byte plus this overhead.
	localparam logic [NEED_W-1:0] LEN_OVERHEAD = 9'd3;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_GOOD = 3'd1,
		EV_BAD  = 3'd2,
		EV_LEN  = 3'd3,
		EV_READ = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_READ,
		ST_RDATA,
		ST_CHK,
		ST_SCAN,
		ST_LEN,
		ST_OUT
	} state_t;

	// Circular buffer address: base plus logical offset, wrapped at the depth.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [PTR_W+1:0] s;
		s = (PTR_W+2)'(base) + (PTR_W+2)'(off);
		if (s >= (PTR_W+2)'(BUF_DEPTH)) begin
			s = s - (PTR_W+2)'(BUF_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

### design/slxfr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module slxfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/sync_length_xor_frame_receiver_top.sv
`timescale 1ns / 1ps
// A byte that completes no frame, or a store read, passes from the capture state through its
// byte or read states to the output state; a completing byte adds one assembly-buffer read per
// frame byte and, on a checksum failure, a resync scan of one buffered byte per cycle.
// One beat is taken at a time: s_axis_tready is high only in idle, once the last result is in
// the output register; the checksum pass and resync scan share the single assembly-buffer read port.
// Reset (arst_n low) clears counters, lengths and registers to their defaults; buffer contents
// are left as they are and need no clearing pass.
module sync_length_xor_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input beats.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], read_index[14:8], zero pad[15]
	input  logic        s_axis_tuser,   // req_type
	// Result beats.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // frame_length, read_data, good_count, bad_count
	output logic [2:0]  m_axis_tuser    // event_code
);

	localparam int PTR_W  = slxfr_pkg::PTR_W;
	localparam int CNT_W  = slxfr_pkg::CNT_W;
	localparam int BYTE_W = slxfr_pkg::BYTE_W;
	localparam int NEED_W = slxfr_pkg::NEED_W;
	localparam int CTR_W  = slxfr_pkg::CTR_W;

	slxfr_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [BYTE_W-1:0] sync_q, min_q, max_q;

	// Captured input beat.
	logic [BYTE_W-1:0] rx_q;
	logic [6:0]        rd_idx_q;

	// Assembly state: circular buffer head, fill count, copy of the length byte.
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] len_q;
	logic [CNT_W-1:0]  n_q;

	// Sweep pointer and its read pipeline stage.
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_s1;
	logic              vld_s1;
	logic [BYTE_W-1:0] xor_q;

	// Stored frame and statistics.
	logic              bank_q;
	logic [BYTE_W-1:0] slen_q;
	logic [CTR_W-1:0]  good_q, bad_q;

	// Pending result and output register.
	slxfr_pkg::event_t res_ev_q;
	logic [BYTE_W-1:0] res_data_q;
	logic              out_valid_q;
	logic [2:0]        out_ev_q;
	logic [47:0]       out_data_q;

	// Memory ports.
	logic              abuf_we;
	logic [PTR_W-1:0]  abuf_waddr, abuf_raddr;
	logic [BYTE_W-1:0] abuf_wdata, abuf_rdata;
	logic              fs_we;
	logic [PTR_W:0]    fs_waddr, fs_raddr;
	logic [BYTE_W-1:0] fs_wdata, fs_rdata;

	// Byte analysis.
	logic [CNT_W-1:0]  cnt0, cnt1;
	logic              skip, has_len, len_bad, need_more, go_chk;
	logic [BYTE_W-1:0] lenv;
	logic [NEED_W-1:0] needed, cap;

	// Sweep control.
	logic              in_acc, issue, chk_last, chk_good, scan_hit, scan_end, out_free;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	slxfr_ram #(.WIDTH(BYTE_W), .DEPTH(slxfr_pkg::BUF_DEPTH)) u_abuf (
		.clk   (clk),
		.we    (abuf_we),
		.waddr (abuf_waddr),
		.wdata (abuf_wdata),
		.raddr (abuf_raddr),
		.rdata (abuf_rdata)
	);

	slxfr_ram #(.WIDTH(BYTE_W), .DEPTH(2 * slxfr_pkg::BUF_DEPTH)) u_fstore (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	// Decide what a received byte does to the assembly buffer.
	always_comb begin
		cnt0      = (count_q >= CNT_W'(slxfr_pkg::BUF_DEPTH)) ? '0 : count_q;
		skip      = (cnt0 == '0) && (rx_q != sync_q);
		cnt1      = cnt0 + CNT_W'(1);
		has_len   = !skip && (cnt1 >= CNT_W'(2));
		lenv      = (cnt0 == CNT_W'(1)) ? rx_q : len_q;
		needed    = {1'b0, lenv} + slxfr_pkg::LEN_OVERHEAD;
		cap       = ({1'b0, max_q} > NEED_W'(slxfr_pkg::BUF_DEPTH)) ?
			NEED_W'(slxfr_pkg::BUF_DEPTH) : {1'b0, max_q};
		len_bad   = (needed < {1'b0, min_q}) || (needed > cap);
		need_more = NEED_W'(cnt1) < needed;
		go_chk    = has_len && !len_bad && !need_more;
	end

	// Sweep status for checksum and resync scan.
	always_comb begin
		issue    = (state_q == slxfr_pkg::ST_CHK) ? (idx_q < n_q) : (idx_q < count_q);
		chk_last = vld_s1 && (idx_s1 == n_q - CNT_W'(1));
		chk_good = abuf_rdata == xor_q;
		scan_hit = vld_s1 && (abuf_rdata == sync_q);
		scan_end = idx_q >= count_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			slxfr_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = s_axis_tuser ? slxfr_pkg::ST_READ : slxfr_pkg::ST_BYTE;
				end
			end
			slxfr_pkg::ST_BYTE: begin
				state_d = go_chk ? slxfr_pkg::ST_CHK : slxfr_pkg::ST_OUT;
			end
			slxfr_pkg::ST_READ:  state_d = slxfr_pkg::ST_RDATA;
			slxfr_pkg::ST_RDATA: state_d = slxfr_pkg::ST_OUT;
			slxfr_pkg::ST_CHK: begin
				if (chk_last) begin
					state_d = chk_good ? slxfr_pkg::ST_OUT : slxfr_pkg::ST_SCAN;
				end
			end
			slxfr_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = slxfr_pkg::ST_LEN;
				end else if (scan_end) begin
					state_d = slxfr_pkg::ST_OUT;
				end
			end
			slxfr_pkg::ST_LEN: state_d = slxfr_pkg::ST_OUT;
			slxfr_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = slxfr_pkg::ST_IDLE;
				end
			end
			default: state_d = slxfr_pkg::ST_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		s_axis_tready = 1'b0;
		abuf_we       = 1'b0;
		abuf_waddr    = slxfr_pkg::wrap_add(head_q, cnt0);
		abuf_wdata    = rx_q;
		abuf_raddr    = slxfr_pkg::wrap_add(head_q, idx_q);
		fs_we         = 1'b0;
		fs_waddr      = {~bank_q, idx_s1[PTR_W-1:0]};
		fs_wdata      = abuf_rdata;
		fs_raddr      = {bank_q, PTR_W'(rd_idx_q)};
		case (state_q)
			slxfr_pkg::ST_IDLE: s_axis_tready = 1'b1;
			slxfr_pkg::ST_BYTE: abuf_we = !skip;
			slxfr_pkg::ST_CHK:  fs_we = vld_s1;
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= slxfr_pkg::SYNC_RST;
			min_q  <= slxfr_pkg::MIN_RST;
			max_q  <= slxfr_pkg::MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slxfr_pkg::REG_SYNC: sync_q <= cfg_data;
				slxfr_pkg::REG_MIN:  min_q  <= cfg_data;
				slxfr_pkg::REG_MAX:  max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath and bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slxfr_pkg::ST_IDLE;
			rx_q        <= '0;
			rd_idx_q    <= '0;
			head_q      <= '0;
			count_q     <= '0;
			len_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			xor_q       <= '0;
			bank_q      <= 1'b0;
			slen_q      <= '0;
			good_q      <= '0;
			bad_q       <= '0;
			res_ev_q    <= slxfr_pkg::EV_NONE;
			res_data_q  <= '0;
			out_valid_q <= 1'b0;
			out_ev_q    <= '0;
			out_data_q  <= '0;
		end else begin
			state_q <= state_d;

			// The output register loads a new result or drains independently of the sequencer.
			if (state_q == slxfr_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				slxfr_pkg::ST_IDLE: begin
					if (in_acc) begin
						rx_q     <= s_axis_tdata[7:0];
						rd_idx_q <= s_axis_tdata[14:8];
					end
				end

				slxfr_pkg::ST_BYTE: begin
					res_data_q <= '0;
					res_ev_q   <= (has_len && len_bad) ? slxfr_pkg::EV_LEN : slxfr_pkg::EV_NONE;
					if (skip) begin
						count_q <= cnt0;
					end else if (has_len && len_bad) begin
						count_q <= '0;
					end else begin
						count_q <= cnt1;
					end
					if (!skip && cnt0 == CNT_W'(1)) begin
						len_q <= rx_q;
					end
					if (go_chk) begin
						n_q    <= CNT_W'(needed);
						idx_q  <= '0;
						vld_s1 <= 1'b0;
						xor_q  <= '0;
					end
				end

				slxfr_pkg::ST_RDATA: begin
					res_ev_q   <= slxfr_pkg::EV_READ;
					res_data_q <= ({1'b0, rd_idx_q} < slen_q) ? fs_rdata : '0;
				end

				slxfr_pkg::ST_CHK: begin
					// No read is issued once the last byte is back, so the stage empties itself.
					vld_s1 <= issue;
					idx_s1 <= idx_q;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (vld_s1 && idx_s1 != '0 && !chk_last) begin
						xor_q <= xor_q ^ abuf_rdata;
					end
					// Last byte holds the checksum.
					if (chk_last) begin
						res_data_q <= '0;
						if (chk_good) begin
							res_ev_q <= slxfr_pkg::EV_GOOD;
							bank_q   <= ~bank_q;
							slen_q   <= BYTE_W'(n_q);
							good_q   <= good_q + CTR_W'(1);
							count_q  <= '0;
						end else begin
							res_ev_q <= slxfr_pkg::EV_BAD;
							bad_q    <= bad_q + CTR_W'(1);
							idx_q    <= CNT_W'(1);
						end
					end
				end

				slxfr_pkg::ST_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= idx_q;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					// The read issued alongside a hit fetches the new length byte.
					if (scan_hit) begin
						head_q  <= slxfr_pkg::wrap_add(head_q, idx_s1);
						count_q <= count_q - idx_s1;
					end else if (scan_end) begin
						count_q <= '0;
					end
				end

				slxfr_pkg::ST_LEN: begin
					len_q <= abuf_rdata;
				end

				slxfr_pkg::ST_OUT: begin
					if (out_free) begin
						out_ev_q   <= res_ev_q;
						out_data_q <= {bad_q, good_q, res_data_q, slen_q};
					end
				end

				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ev_q;

endmodule
